// ===== design/bma_pkg.sv =====
package bma_pkg;

    localparam int BLOCK_COUNT_W   = 11;
    localparam int SIZE_W          = 32;
    localparam int OFF_W           = 22;
    localparam int USED_W          = 11;
    localparam int MAX_BLOCKS_DEF  = 1024;
    localparam int BLOCK_BYTES_DEF = 4096;

    localparam logic [BLOCK_COUNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        MARK_FREE  = 2'd0,
        MARK_START = 2'd1,
        MARK_ALLOC = 2'd2
    } mark_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_NOMEM   = 2'd1,
        ERR_BADFREE = 2'd2
    } err_t;

    typedef struct packed {
        func_t              func;
        logic [SIZE_W-1:0]  size_bytes;
        logic [OFF_W-1:0]   offset_bytes;
    } req_t;

    typedef struct packed {
        logic               ok;
        err_t               error_code;
        logic [OFF_W-1:0]   result_offset;
        logic [USED_W-1:0]  blocks_in_use;
    } rsp_t;

endpackage

// ===== design/bitmap_next_fit_block_allocator.sv =====
// Channel   Signals                      Direction  Handshake
// request   req (func/size/offset)       in         start & !busy
// result    rsp (ok/err/offset/used)     out        done, one cycle, no stall
// config    cfg_data (block_count)       in         cfg_we
//
// Allocate: one mark per cycle from the mark RAM read port, up to block_count
// marks scanned, then one mark written per block of the run.
// Free: one reciprocal multiply step, one check, then a walk that frees each
// block of the run and reads on to find its end, or stops at the heap end.
// After reset and after each block_count write a clearing pass over all MAX_BLOCKS
// marks runs with busy high. Results are never held off by the receiver.
module bitmap_next_fit_block_allocator
    import bma_pkg::*;
#(
    parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [BLOCK_COUNT_W-1:0]  cfg_data,
    input  logic                      start,
    input  req_t                      req,
    output logic                      busy,
    output logic                      done,
    output rsp_t                      rsp
);

    localparam int IW   = $clog2(MAX_BLOCKS);
    localparam int CW   = $clog2(MAX_BLOCKS + 1);
    localparam int CMPW = (CW > BLOCK_COUNT_W) ? CW : BLOCK_COUNT_W;

    logic [BLOCK_COUNT_W-1:0] block_count_reg;
    logic [CMPW-1:0]          count_wide;
    logic [CW-1:0]            count;

    logic                     mem_we;
    logic [IW-1:0]            mem_waddr;
    mark_t                    mem_wdata;
    logic [IW-1:0]            mem_raddr;
    mark_t                    mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= BLOCK_COUNT_RST;
        end
        else if (cfg_we)
        begin
            block_count_reg <= cfg_data;
        end
    end

    // zero acts as one, above the heap acts as the heap size
    assign count_wide = (block_count_reg == '0) ? CMPW'(1) :
                        (CMPW'(block_count_reg) > CMPW'(MAX_BLOCKS)) ? CMPW'(MAX_BLOCKS) :
                        CMPW'(block_count_reg);
    assign count      = count_wide[CW-1:0];

    bma_seq #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .count     (count),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .done      (done),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bma_mark_ram #(
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start) || $past(busy)))
        else $error("result without a request in progress");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.ok) |-> (rsp.result_offset == '0 && rsp.error_code != ERR_NONE))
        else $error("failed result carries offset or no error code");

    a_ok_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.ok) |-> (rsp.error_code == ERR_NONE))
        else $error("successful result carries an error code");

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> busy)
        else $error("no clearing pass after block_count write");

endmodule

// ===== design/bma_mark_ram.sv =====
module bma_mark_ram
    import bma_pkg::*;
#(
    parameter int DEPTH = MAX_BLOCKS_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  mark_t                    wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output mark_t                    rdata
);

    mark_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/bma_seq.sv =====
module bma_seq
    import bma_pkg::*;
#(
    parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0]  count,
    input  logic                             start,
    input  req_t                             req,
    output logic                             busy,
    output logic                             done,
    output rsp_t                             rsp,
    output logic                             mem_we,
    output logic [$clog2(MAX_BLOCKS)-1:0]    mem_waddr,
    output mark_t                            mem_wdata,
    output logic [$clog2(MAX_BLOCKS)-1:0]    mem_raddr,
    input  mark_t                            mem_rdata
);

    localparam int IW  = $clog2(MAX_BLOCKS);
    localparam int CW  = $clog2(MAX_BLOCKS + 1);
    localparam int BBW = $clog2(BLOCK_BYTES + 1);
    localparam int RBW = CW + BBW;
    localparam int CPW = (RBW > SIZE_W) ? RBW : SIZE_W;
    localparam int QCW = (CW > OFF_W) ? CW : OFF_W;
    localparam int PW  = (IW + BBW > OFF_W) ? IW + BBW : OFF_W;
    localparam int UW  = (CW > USED_W) ? CW : USED_W;

    // reciprocal of the block size, exact floor for any offset of OFF_W bits
    localparam int              RSH   = OFF_W + $clog2(BLOCK_BYTES);
    localparam int              QPW   = 2 * OFF_W + 1;
    localparam longint unsigned RECIP = ((64'd1 << RSH) + 64'(BLOCK_BYTES) - 64'd1) /
                                        64'(BLOCK_BYTES);
    localparam logic [OFF_W:0]  RECIP_V = (OFF_W+1)'(RECIP);

    localparam logic [IW-1:0] LAST_BLK = IW'(MAX_BLOCKS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_DIV,
        ST_FCHK,
        ST_FWALK
    } state_t;

    state_t                state_reg,  state_next;
    logic [IW-1:0]         cur_reg,    cur_next;
    logic [CW-1:0]         n_reg,      n_next;
    logic [CW-1:0]         run_reg,    run_next;
    logic [RBW-1:0]        rbytes_reg, rbytes_next;
    logic [IW-1:0]         idx_reg,    idx_next;
    logic [SIZE_W-1:0]     size_reg,   size_next;
    logic [IW-1:0]         roving_reg, roving_next;
    logic [CW-1:0]         used_reg,   used_next;
    logic [CW-1:0]         left_reg,   left_next;
    logic                  first_reg,  first_next;
    logic [OFF_W-1:0]      q_reg,      q_next;
    logic [OFF_W-1:0]      osh_reg,    osh_next;
    logic                  done_reg,   done_next;
    rsp_t                  rsp_reg,    rsp_next;

    logic [CW-1:0]         cur_inc;
    logic [IW-1:0]         cur_wrap;
    logic [IW-1:0]         start_ptr;
    logic [CW-1:0]         run_base;
    logic [RBW-1:0]        bytes_base;
    logic [CW-1:0]         run_add;
    logic [RBW-1:0]        bytes_add;
    logic [IW-1:0]         idx_add;
    logic                  hit;
    logic [QPW-1:0]        qprod;
    logic [CW-1:0]         used_dec;
    logic [PW-1:0]         prod;

    function automatic rsp_t make_rsp(logic ok, err_t ec, logic [OFF_W-1:0] off,
                                      logic [CW-1:0] used);
        rsp_t          r;
        logic [UW-1:0] u;
        u                = UW'(used);
        r.ok             = ok;
        r.error_code     = ec;
        r.result_offset  = off;
        r.blocks_in_use  = u[USED_W-1:0];
        return r;
    endfunction

    assign cur_inc    = CW'(cur_reg) + CW'(1);
    assign cur_wrap   = (cur_inc == count) ? '0 : cur_inc[IW-1:0];
    assign start_ptr  = (CW'(roving_reg) < count) ? roving_reg : '0;
    // a run may not wrap past the heap end
    assign run_base   = (cur_reg == '0) ? '0 : run_reg;
    assign bytes_base = (cur_reg == '0) ? '0 : rbytes_reg;
    assign run_add    = run_base + CW'(1);
    assign bytes_add  = bytes_base + RBW'(BLOCK_BYTES);
    assign idx_add    = (run_base == '0) ? cur_reg : idx_reg;
    assign hit        = (mem_rdata == MARK_FREE) && (CPW'(bytes_add) >= CPW'(size_reg));

    assign qprod      = QPW'(osh_reg) * QPW'(RECIP_V);

    assign used_dec   = (used_reg != '0) ? used_reg - CW'(1) : used_reg;
    assign prod       = PW'(idx_reg) * PW'(BLOCK_BYTES);

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        n_next      = n_reg;
        run_next    = run_reg;
        rbytes_next = rbytes_reg;
        idx_next    = idx_reg;
        size_next   = size_reg;
        roving_next = roving_reg;
        used_next   = used_reg;
        left_next   = left_reg;
        first_next  = first_reg;
        q_next      = q_reg;
        osh_next    = osh_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        mem_we      = 1'b0;
        mem_waddr   = cur_reg;
        mem_wdata   = MARK_FREE;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                cur_next = cur_reg + IW'(1);
                if (cur_reg == LAST_BLK)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req.func == FUNC_FREE)
                    begin
                        osh_next   = req.offset_bytes;
                        state_next = ST_DIV;
                    end
                    else if (req.size_bytes == '0)
                    begin
                        done_next = 1'b1;
                        rsp_next  = make_rsp(1'b0, ERR_NOMEM, '0, used_reg);
                    end
                    else
                    begin
                        size_next   = req.size_bytes;
                        cur_next    = start_ptr;
                        idx_next    = start_ptr;
                        n_next      = '0;
                        run_next    = '0;
                        rbytes_next = '0;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    roving_next = cur_wrap;
                    idx_next    = idx_add;
                    left_next   = run_add;
                    cur_next    = idx_add;
                    first_next  = 1'b1;
                    state_next  = ST_MARK;
                end
                else if (n_reg + CW'(1) == count)
                begin
                    done_next  = 1'b1;
                    rsp_next   = make_rsp(1'b0, ERR_NOMEM, '0, used_reg);
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_next = cur_wrap;
                    n_next   = n_reg + CW'(1);
                    if (mem_rdata == MARK_FREE)
                    begin
                        run_next    = run_add;
                        rbytes_next = bytes_add;
                        idx_next    = idx_add;
                    end
                    else
                    begin
                        run_next    = '0;
                        rbytes_next = '0;
                    end
                end
            end
            ST_MARK:
            begin
                mem_we     = 1'b1;
                mem_wdata  = first_reg ? MARK_START : MARK_ALLOC;
                first_next = 1'b0;
                cur_next   = cur_reg + IW'(1);
                used_next  = used_reg + CW'(1);
                left_next  = left_reg - CW'(1);
                if (left_reg == CW'(1))
                begin
                    done_next  = 1'b1;
                    rsp_next   = make_rsp(1'b1, ERR_NONE, prod[OFF_W-1:0],
                                          used_reg + CW'(1));
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                q_next     = OFF_W'(qprod >> RSH);
                state_next = ST_FCHK;
            end
            ST_FCHK:
            begin
                if (QCW'(q_reg) >= QCW'(count))
                begin
                    done_next  = 1'b1;
                    rsp_next   = make_rsp(1'b0, ERR_BADFREE, '0, used_reg);
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_next   = q_reg[IW-1:0];
                    first_next = 1'b1;
                    state_next = ST_FWALK;
                end
            end
            ST_FWALK:
            begin
                if (first_reg && (mem_rdata != MARK_START))
                begin
                    done_next  = 1'b1;
                    rsp_next   = make_rsp(1'b0, ERR_BADFREE, '0, used_reg);
                    state_next = ST_IDLE;
                end
                else if (!first_reg && (mem_rdata != MARK_ALLOC))
                begin
                    done_next  = 1'b1;
                    rsp_next   = make_rsp(1'b1, ERR_NONE, '0, used_reg);
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_we     = 1'b1;
                    used_next  = used_dec;
                    first_next = 1'b0;
                    if (cur_inc < count)
                    begin
                        cur_next = cur_inc[IW-1:0];
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        rsp_next   = make_rsp(1'b1, ERR_NONE, '0, used_dec);
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                cur_next   = '0;
            end
        endcase

        // heap reinit on a block_count write
        if (cfg_we)
        begin
            state_next  = ST_CLEAR;
            cur_next    = '0;
            roving_next = '0;
            used_next   = '0;
        end
    end

    assign mem_raddr = cur_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            cur_reg    <= '0;
            roving_reg <= '0;
            used_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cur_reg    <= cur_next;
            roving_reg <= roving_next;
            used_reg   <= used_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        run_reg    <= run_next;
        rbytes_reg <= rbytes_next;
        idx_reg    <= idx_next;
        size_reg   <= size_next;
        left_reg   <= left_next;
        first_reg  <= first_next;
        q_reg      <= q_next;
        osh_reg    <= osh_next;
        rsp_reg    <= rsp_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
